/* src/clpg_pkg.sv */
// Shared types, codes and helpers for the cell list pair generator.
// No dependencies; used by clpg_seq and cell_list_pair_generator.
`default_nettype none

package clpg_pkg;

  localparam int CELL_CAP_DEF = 32;
  localparam int ID_WIDTH_DEF = 16;
  localparam int REQ_W = 3;
  localparam int SP_W  = 2;
  localparam int ROW_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLR_HOME = 3'd0,
    REQ_LD_HOME  = 3'd1,
    REQ_CLR_NBR  = 3'd2,
    REQ_LD_NBR   = 3'd3,
    REQ_SELF     = 3'd4,
    REQ_CROSS    = 3'd5,
    REQ_SINGLE   = 3'd6
  } req_e;

  localparam logic [SP_W-1:0] SP_RECEPTOR  = 2'd1;
  localparam logic [SP_W-1:0] SP_CROSSLINK = 2'd2;

  // store write enables from the sequencer
  typedef struct packed {
    logic home_we;
    logic nbr_we;
  } wr_t;

  // s: home object, t: partner; code 3 behaves as other
  function automatic logic pair_allowed(logic [SP_W-1:0] s, logic [SP_W-1:0] t);
    logic ok;
    if (s == SP_RECEPTOR) begin
      ok = (t == SP_CROSSLINK);
    end else if (s == SP_CROSSLINK) begin
      ok = 1'b1;
    end else begin
      ok = (t != SP_RECEPTOR);
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

/* src/cell_list_pair_generator.sv */
// Top level of the cell list pair generator: home and neighbor stores,
// sequencer and stream packing. Depends on clpg_pkg, clpg_ram, clpg_seq.
`default_nettype none

// Clear and load requests finish as they are accepted. A self or cross row
// request first fetches the home entry, then walks the stored entries one at
// a time (from slot i+1 for a self row, over the whole neighbor store for a
// cross row), then sends the final pair. A single-object request walks the
// home store from slot 0. The walk is set by the single read port of each
// store; output backpressure stalls it. At most one pair leaves per cycle
// when the output is not stalled, and the last pair of a request has tlast
// set. The block takes one request at a time.
module cell_list_pair_generator #(
  parameter int CELL_CAP = clpg_pkg::CELL_CAP_DEF,
  parameter int ID_WIDTH = clpg_pkg::ID_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // object_id, species, row_index (zero padded to bytes)
  input  logic [((ID_WIDTH+clpg_pkg::SP_W+clpg_pkg::ROW_W+7)/8)*8-1:0] s_axis_tdata_i,
  // req_type
  input  logic [clpg_pkg::REQ_W-1:0] s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // first_id, second_id (zero padded to bytes)
  output logic [((2*ID_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // last_pair
  output logic m_axis_tlast_o
);

  localparam int IDX_W  = $clog2(CELL_CAP);
  localparam int CNT_W  = $clog2(CELL_CAP + 1);
  localparam int ENT_W  = ID_WIDTH + clpg_pkg::SP_W;
  localparam int OUT_W  = ((2 * ID_WIDTH + 7) / 8) * 8;

  logic [ID_WIDTH-1:0]           in_id, out_first, out_second;
  logic [clpg_pkg::SP_W-1:0]     in_sp;
  logic [clpg_pkg::ROW_W-1:0]    in_row;
  clpg_pkg::wr_t                 wr;
  logic [IDX_W-1:0]              waddr, raddr;
  logic [ENT_W-1:0]              home_rdata, nbr_rdata;
  logic [CNT_W-1:0]              home_cnt, nbr_cnt;

  assign in_id  = s_axis_tdata_i[ID_WIDTH-1:0];
  assign in_sp  = s_axis_tdata_i[ENT_W-1:ID_WIDTH];
  assign in_row = s_axis_tdata_i[ENT_W+clpg_pkg::ROW_W-1:ENT_W];

  clpg_ram #(.WIDTH(ENT_W), .DEPTH(CELL_CAP)) u_home_ram (
    .clk_i   (clk_i),
    .we_i    (wr.home_we),
    .waddr_i (waddr),
    .wdata_i ({in_sp, in_id}),
    .raddr_i (raddr),
    .rdata_o (home_rdata)
  );

  clpg_ram #(.WIDTH(ENT_W), .DEPTH(CELL_CAP)) u_nbr_ram (
    .clk_i   (clk_i),
    .we_i    (wr.nbr_we),
    .waddr_i (waddr),
    .wdata_i ({in_sp, in_id}),
    .raddr_i (raddr),
    .rdata_o (nbr_rdata)
  );

  clpg_seq #(.CELL_CAP(CELL_CAP), .ID_WIDTH(ID_WIDTH)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .req_i        (s_axis_tuser_i),
    .id_i         (in_id),
    .row_i        (in_row),
    .wr_o         (wr),
    .waddr_o      (waddr),
    .raddr_o      (raddr),
    .home_rdata_i (home_rdata),
    .nbr_rdata_i  (nbr_rdata),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_first_o  (out_first),
    .out_second_o (out_second),
    .out_last_o   (m_axis_tlast_o),
    .home_cnt_o   (home_cnt),
    .nbr_cnt_o    (nbr_cnt)
  );

  assign m_axis_tdata_o = OUT_W'({out_second, out_first});

  a_home_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    home_cnt <= CNT_W'(CELL_CAP))
    else $error("home count above capacity");

  a_nbr_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nbr_cnt <= CNT_W'(CELL_CAP))
    else $error("neighbor count above capacity");

  a_home_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == clpg_pkg::REQ_LD_HOME
     && home_cnt < CNT_W'(CELL_CAP))
    |=> home_cnt == $past(home_cnt) + CNT_W'(1))
    else $error("home load not counted");

  a_nbr_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == clpg_pkg::REQ_CLR_NBR)
    |=> nbr_cnt == '0)
    else $error("neighbor clear not applied");

endmodule

`default_nettype wire

/* src/clpg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module clpg_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/clpg_seq.sv */
// Request sequencer: fill counts, store addressing, row walk with species
// filter, one-deep pending pair and output register. Depends on clpg_pkg.
`default_nettype none

module clpg_seq #(
  parameter int CELL_CAP = clpg_pkg::CELL_CAP_DEF,
  parameter int ID_WIDTH = clpg_pkg::ID_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [clpg_pkg::REQ_W-1:0]      req_i,
  input  logic [ID_WIDTH-1:0]             id_i,
  input  logic [clpg_pkg::ROW_W-1:0]      row_i,
  output clpg_pkg::wr_t                   wr_o,
  output logic [$clog2(CELL_CAP)-1:0]     waddr_o,
  output logic [$clog2(CELL_CAP)-1:0]     raddr_o,
  input  logic [ID_WIDTH+clpg_pkg::SP_W-1:0] home_rdata_i,
  input  logic [ID_WIDTH+clpg_pkg::SP_W-1:0] nbr_rdata_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ID_WIDTH-1:0]             out_first_o,
  output logic [ID_WIDTH-1:0]             out_second_o,
  output logic                            out_last_o,
  output logic [$clog2(CELL_CAP+1)-1:0]   home_cnt_o,
  output logic [$clog2(CELL_CAP+1)-1:0]   nbr_cnt_o
);

  localparam int IDX_W = $clog2(CELL_CAP);
  localparam int CNT_W = $clog2(CELL_CAP + 1);
  localparam int CMP_W = ((CNT_W > clpg_pkg::ROW_W) ? CNT_W : clpg_pkg::ROW_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_WALK,
    ST_FLUSH
  } state_e;

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          home_cnt_q, home_cnt_d, nbr_cnt_q, nbr_cnt_d;
  logic [IDX_W-1:0]          row_q, row_d, j_q, j_d;
  logic                      sel_nbr_q, sel_nbr_d, nofilt_q, nofilt_d;
  logic [ID_WIDTH-1:0]       first_id_q, first_id_d, pend_q, pend_d;
  logic [clpg_pkg::SP_W-1:0] first_sp_q, first_sp_d;
  logic                      pend_valid_q, pend_valid_d;
  logic                      out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [ID_WIDTH-1:0]       out_first_q, out_first_d, out_second_q, out_second_d;

  logic                          accept, can_emit, allowed, advance, at_last;
  logic [ID_WIDTH+clpg_pkg::SP_W-1:0] cur_rdata;
  logic [ID_WIDTH-1:0]           cur_id;
  logic [clpg_pkg::SP_W-1:0]     cur_sp;
  logic [CNT_W-1:0]              walk_end, self_start;
  logic                          row_ok;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign can_emit  = !out_valid_q || out_ready_i;
  assign cur_rdata = sel_nbr_q ? nbr_rdata_i : home_rdata_i;
  assign cur_id    = cur_rdata[ID_WIDTH-1:0];
  assign cur_sp    = cur_rdata[ID_WIDTH+clpg_pkg::SP_W-1:ID_WIDTH];
  assign allowed   = nofilt_q || clpg_pkg::pair_allowed(first_sp_q, cur_sp);
  assign advance   = !allowed || !pend_valid_q || can_emit;
  assign walk_end  = sel_nbr_q ? nbr_cnt_q : home_cnt_q;
  assign at_last   = (CNT_W'(j_q) == (walk_end - CNT_W'(1)));
  assign self_start = CNT_W'(row_q) + CNT_W'(1);
  assign row_ok    = CMP_W'(row_i) < CMP_W'(home_cnt_q);

  always_comb begin
    state_d      = state_q;
    home_cnt_d   = home_cnt_q;
    nbr_cnt_d    = nbr_cnt_q;
    row_d        = row_q;
    j_d          = j_q;
    sel_nbr_d    = sel_nbr_q;
    nofilt_d     = nofilt_q;
    first_id_d   = first_id_q;
    first_sp_d   = first_sp_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q;
    out_last_d   = out_last_q;
    out_first_d  = out_first_q;
    out_second_d = out_second_q;
    wr_o         = '0;
    waddr_o      = IDX_W'(home_cnt_q);
    raddr_o      = j_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        raddr_o = (req_i == clpg_pkg::REQ_SINGLE) ? '0 : IDX_W'(row_i);
        if (req_i == clpg_pkg::REQ_LD_NBR) begin
          waddr_o = IDX_W'(nbr_cnt_q);
        end
        pend_valid_d = 1'b0;
        if (accept) begin
          case (req_i)
            clpg_pkg::REQ_CLR_HOME: home_cnt_d = '0;
            clpg_pkg::REQ_CLR_NBR:  nbr_cnt_d = '0;
            clpg_pkg::REQ_LD_HOME: begin
              if (home_cnt_q < CNT_W'(CELL_CAP)) begin
                wr_o.home_we = 1'b1;
                home_cnt_d   = home_cnt_q + CNT_W'(1);
              end
            end
            clpg_pkg::REQ_LD_NBR: begin
              if (nbr_cnt_q < CNT_W'(CELL_CAP)) begin
                wr_o.nbr_we = 1'b1;
                nbr_cnt_d   = nbr_cnt_q + CNT_W'(1);
              end
            end
            clpg_pkg::REQ_SELF, clpg_pkg::REQ_CROSS: begin
              if (row_ok) begin
                state_d   = ST_ROW;
                row_d     = IDX_W'(row_i);
                sel_nbr_d = (req_i == clpg_pkg::REQ_CROSS);
                nofilt_d  = 1'b0;
              end
            end
            clpg_pkg::REQ_SINGLE: begin
              if (home_cnt_q != '0) begin
                state_d    = ST_WALK;
                first_id_d = id_i;
                nofilt_d   = 1'b1;
                sel_nbr_d  = 1'b0;
                j_d        = '0;
              end
            end
            default: ;
          endcase
        end
      end

      ST_ROW: begin
        // home entry of the requested row is on the read port now
        first_id_d = home_rdata_i[ID_WIDTH-1:0];
        first_sp_d = home_rdata_i[ID_WIDTH+clpg_pkg::SP_W-1:ID_WIDTH];
        if (sel_nbr_q) begin
          j_d     = '0;
          raddr_o = '0;
          state_d = (nbr_cnt_q != '0) ? ST_WALK : ST_IDLE;
        end else begin
          j_d     = IDX_W'(self_start);
          raddr_o = IDX_W'(self_start);
          state_d = (self_start < home_cnt_q) ? ST_WALK : ST_IDLE;
        end
      end

      ST_WALK: begin
        // a kept pair waits in pend until the next one shows it was not the last
        if (allowed && advance) begin
          if (pend_valid_q) begin
            out_valid_d  = 1'b1;
            out_first_d  = first_id_q;
            out_second_d = pend_q;
            out_last_d   = 1'b0;
          end
          pend_d       = cur_id;
          pend_valid_d = 1'b1;
        end
        if (advance) begin
          if (at_last) begin
            state_d = ST_FLUSH;
          end else begin
            j_d     = j_q + IDX_W'(1);
            raddr_o = j_q + IDX_W'(1);
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (can_emit) begin
          out_valid_d  = 1'b1;
          out_first_d  = first_id_q;
          out_second_d = pend_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      home_cnt_q   <= '0;
      nbr_cnt_q    <= '0;
      row_q        <= '0;
      j_q          <= '0;
      sel_nbr_q    <= 1'b0;
      nofilt_q     <= 1'b0;
      first_id_q   <= '0;
      first_sp_q   <= '0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_first_q  <= '0;
      out_second_q <= '0;
    end else begin
      state_q      <= state_d;
      home_cnt_q   <= home_cnt_d;
      nbr_cnt_q    <= nbr_cnt_d;
      row_q        <= row_d;
      j_q          <= j_d;
      sel_nbr_q    <= sel_nbr_d;
      nofilt_q     <= nofilt_d;
      first_id_q   <= first_id_d;
      first_sp_q   <= first_sp_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
      out_first_q  <= out_first_d;
      out_second_q <= out_second_d;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_first_o  = out_first_q;
  assign out_second_o = out_second_q;
  assign out_last_o   = out_last_q;
  assign home_cnt_o   = home_cnt_q;
  assign nbr_cnt_o    = nbr_cnt_q;

endmodule

`default_nettype wire
